### rtl/cdll_pkg.sv
// Shared types and codes for the cursor doubly linked list manager.
package cdll_pkg;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREV   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HOME   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_AT_SENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic load;     // read links of cursor node and top of free stack
        logic exec;     // first write pass, cursor and counters update
        logic fin;      // second link write pass, value read at cursor
        logic capt;     // result captured into the output register
    } cmd_t;

endpackage

### rtl/cdll_ctrl.sv
// Sequencing state machine and output valid for the list manager.
module cdll_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output cdll_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_CAPT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   capt_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    // result register frees up when its transaction completes
    assign capt_fire = (state_reg == ST_CAPT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_FIN;
            ST_FIN:  state_next = ST_CAPT;
            ST_CAPT: begin
                if (capt_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (capt_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_comb begin
        cmd.accept = s_valid && (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_LOAD);
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.fin    = (state_reg == ST_FIN);
        cmd.capt   = capt_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/cdll_dp.sv
// Datapath: node pool memories, free stack, cursor, counters and result register.
module cdll_dp #(
    parameter int POOL_NODES = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cdll_pkg::cmd_t                    cmd,
    input  logic [cdll_pkg::FUNC_W-1:0]       s_func,
    input  logic [cdll_pkg::DATA_W-1:0]       s_item_value,
    output logic [cdll_pkg::STATUS_W-1:0]     m_status,
    output logic                              m_at_sentinel,
    output logic                              m_list_empty,
    output logic [cdll_pkg::COUNT_W-1:0]      m_entry_count,
    output logic [cdll_pkg::DATA_W-1:0]       m_cursor_value
);

    localparam int NODE_W    = $clog2(POOL_NODES);
    localparam int STK_DEPTH = POOL_NODES - 1;
    localparam int STK_W     = $clog2(STK_DEPTH);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(POOL_NODES - 1);
    localparam logic [NODE_W-1:0] SENT      = '0;
    localparam logic [NODE_W-1:0] ONE       = NODE_W'(1);

    // node pool; entry 0 of the link arrays lives in flops below
    logic [NODE_W-1:0]     fwd_mem [POOL_NODES];
    logic [NODE_W-1:0]     bwd_mem [POOL_NODES];
    logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
    logic [NODE_W-1:0]     stk_mem [STK_DEPTH];

    // control state
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic [NODE_W-1:0] count_reg, count_next;
    logic [NODE_W-1:0] top_reg, top_next;
    logic [NODE_W-1:0] low_reg, low_next;   // lowest stack slot ever popped
    logic [NODE_W-1:0] fwd0_reg, fwd0_next;
    logic [NODE_W-1:0] bwd0_reg, bwd0_next;

    // payload registers
    logic [cdll_pkg::FUNC_W-1:0]   func_reg;
    logic [VALUE_BITS-1:0]         item_reg;
    logic [NODE_W-1:0]             fwd_rd_reg, bwd_rd_reg, stk_rd_reg;
    logic                          stk_unw_reg, cur0_reg;
    logic [NODE_W-1:0]             after_reg, fresh_reg;
    logic [cdll_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_BITS-1:0]         val_rd_reg;
    logic [cdll_pkg::STATUS_W-1:0] m_status_reg;
    logic                          m_at_sentinel_reg, m_list_empty_reg;
    logic [cdll_pkg::COUNT_W-1:0]  m_entry_count_reg;
    logic [cdll_pkg::DATA_W-1:0]   m_cursor_value_reg;

    logic [63:0]       item_wide, val_wide;
    logic [16:0]       count_wide;
    logic [NODE_W-1:0] top_m1;
    logic [NODE_W-1:0] after_w, before_w, fresh_w;
    logic              ins_ok, rem_ok, ins_fin;

    // link write ports
    logic              fwd_wen, bwd_wen, fwd_mem_we, bwd_mem_we, val_we, stk_we;
    logic [NODE_W-1:0] fwd_wa, fwd_wd, bwd_wa, bwd_wd;

    always_comb begin
        item_wide = 64'(s_item_value);
        val_wide  = '0;
        val_wide[VALUE_BITS-1:0] = val_rd_reg;
        count_wide = 17'(count_reg);
    end

    assign top_m1   = top_reg - ONE;
    assign after_w  = cur0_reg ? fwd0_reg : fwd_rd_reg;
    assign before_w = cur0_reg ? bwd0_reg : bwd_rd_reg;
    // a stack slot never pushed is not read from memory: slot i stands for node i+1, taken from top_reg
    assign fresh_w  = stk_unw_reg ? top_reg : stk_rd_reg;
    assign ins_ok   = (func_reg == cdll_pkg::FUNC_INSERT) && (top_reg != SENT);
    assign rem_ok   = (func_reg == cdll_pkg::FUNC_REMOVE) && (cursor_reg != SENT);
    assign ins_fin  = (func_reg == cdll_pkg::FUNC_INSERT) && (status_reg == cdll_pkg::STAT_OK);

    always_comb begin
        status_next = status_reg;
        if (cmd.exec) begin
            status_next = cdll_pkg::STAT_OK;
            if ((func_reg == cdll_pkg::FUNC_INSERT) && (top_reg == SENT)) begin
                status_next = cdll_pkg::STAT_FULL;
            end else if ((func_reg == cdll_pkg::FUNC_REMOVE) && (cursor_reg == SENT)) begin
                status_next = cdll_pkg::STAT_AT_SENT;
            end
        end
    end

    // link writes: one per array per cycle, sentinel entry steered to flops
    always_comb begin
        fwd_wen = 1'b0;
        fwd_wa  = '0;
        fwd_wd  = '0;
        bwd_wen = 1'b0;
        bwd_wa  = '0;
        bwd_wd  = '0;
        if (cmd.exec && ins_ok) begin
            fwd_wen = 1'b1;
            fwd_wa  = fresh_w;
            fwd_wd  = after_w;
            bwd_wen = 1'b1;
            bwd_wa  = fresh_w;
            bwd_wd  = cursor_reg;
        end else if (cmd.exec && rem_ok) begin
            fwd_wen = 1'b1;
            fwd_wa  = before_w;
            fwd_wd  = after_w;
            bwd_wen = 1'b1;
            bwd_wa  = after_w;
            bwd_wd  = before_w;
        end else if (cmd.fin && ins_fin) begin
            fwd_wen = 1'b1;
            fwd_wa  = cursor_reg;
            fwd_wd  = fresh_reg;
            bwd_wen = 1'b1;
            bwd_wa  = after_reg;
            bwd_wd  = fresh_reg;
        end
        fwd0_next  = fwd0_reg;
        bwd0_next  = bwd0_reg;
        fwd_mem_we = 1'b0;
        bwd_mem_we = 1'b0;
        if (fwd_wen) begin
            if (fwd_wa == SENT) begin
                fwd0_next = fwd_wd;
            end else begin
                fwd_mem_we = 1'b1;
            end
        end
        if (bwd_wen) begin
            if (bwd_wa == SENT) begin
                bwd0_next = bwd_wd;
            end else begin
                bwd_mem_we = 1'b1;
            end
        end
    end

    assign val_we = cmd.exec && ins_ok;
    assign stk_we = cmd.exec && rem_ok && (top_reg < LAST_NODE);

    always_comb begin
        cursor_next = cursor_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        low_next    = low_reg;
        if (cmd.exec) begin
            case (func_reg)
                cdll_pkg::FUNC_NEXT: cursor_next = after_w;
                cdll_pkg::FUNC_PREV: cursor_next = before_w;
                cdll_pkg::FUNC_HOME: cursor_next = SENT;
                cdll_pkg::FUNC_INSERT: begin
                    if (ins_ok) begin
                        count_next = count_reg + ONE;
                        top_next   = top_m1;
                        if (top_m1 < low_reg) begin
                            low_next = top_m1;
                        end
                    end
                end
                cdll_pkg::FUNC_REMOVE: begin
                    if (rem_ok) begin
                        cursor_next = before_w;
                        if (count_reg != SENT) begin
                            count_next = count_reg - ONE;
                        end
                        if (top_reg < LAST_NODE) begin
                            top_next = top_reg + ONE;
                        end
                    end
                end
                default: cursor_next = cursor_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= SENT;
            count_reg  <= '0;
            top_reg    <= LAST_NODE;
            low_reg    <= LAST_NODE;
            fwd0_reg   <= SENT;
            bwd0_reg   <= SENT;
        end else begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            low_reg    <= low_next;
            fwd0_reg   <= fwd0_next;
            bwd0_reg   <= bwd0_next;
        end
    end

    // memory write ports
    always_ff @(posedge aclk) begin
        if (fwd_mem_we) begin
            fwd_mem[fwd_wa] <= fwd_wd;
        end
        if (bwd_mem_we) begin
            bwd_mem[bwd_wa] <= bwd_wd;
        end
        if (val_we) begin
            val_mem[fresh_w] <= item_reg;
        end
        if (stk_we) begin
            stk_mem[top_reg[STK_W-1:0]] <= cursor_reg;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            fwd_rd_reg  <= fwd_mem[cursor_reg];
            bwd_rd_reg  <= bwd_mem[cursor_reg];
            stk_rd_reg  <= stk_mem[top_m1[STK_W-1:0]];
            stk_unw_reg <= (top_m1 < low_reg);
            cur0_reg    <= (cursor_reg == SENT);
        end
        if (cmd.fin) begin
            val_rd_reg <= val_mem[cursor_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_func;
            item_reg <= item_wide[VALUE_BITS-1:0];
        end
        if (cmd.exec) begin
            after_reg <= after_w;
            fresh_reg <= fresh_w;
        end
        status_reg <= status_next;
        if (cmd.capt) begin
            m_status_reg      <= status_reg;
            m_at_sentinel_reg <= (cursor_reg == SENT);
            m_list_empty_reg  <= (fwd0_reg == SENT);
            m_entry_count_reg <= (count_wide > 17'(cdll_pkg::COUNT_MAX)) ?
                                 cdll_pkg::COUNT_MAX : count_wide[cdll_pkg::COUNT_W-1:0];
            m_cursor_value_reg <= (cursor_reg == SENT) ? '0 : val_wide[cdll_pkg::DATA_W-1:0];
        end
    end

    assign m_status       = m_status_reg;
    assign m_at_sentinel  = m_at_sentinel_reg;
    assign m_list_empty   = m_list_empty_reg;
    assign m_entry_count  = m_entry_count_reg;
    assign m_cursor_value = m_cursor_value_reg;

endmodule

### rtl/cursor_doubly_linked_list.sv
// Top level of the cursor doubly linked list manager.
//
//  channel   direction  ports
//  --------  ---------  ---------------------------------------------------------
//  s_        in         s_valid, s_ready, s_func, s_item_value
//  m_        out        m_valid, m_ready, m_status, m_at_sentinel, m_list_empty,
//                       m_entry_count, m_cursor_value
//
// One transaction is in work at a time: accept, link read, first write pass,
// second write pass with cursor value read, result capture. This sequence comes
// from the registered read ports and the single write port of each link memory.
// A held result stalls capture, and with it the next accept; the finished result
// register is drained independently of the next accept.
// Reset (synchronous, aresetn low) puts the cursor on the sentinel with empty
// links and a full free stack; no clearing pass is needed.
module cursor_doubly_linked_list #(
    parameter int POOL_NODES = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cdll_pkg::FUNC_W-1:0]   s_func,
    input  logic [cdll_pkg::DATA_W-1:0]   s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cdll_pkg::STATUS_W-1:0] m_status,
    output logic                          m_at_sentinel,
    output logic                          m_list_empty,
    output logic [cdll_pkg::COUNT_W-1:0]  m_entry_count,
    output logic [cdll_pkg::DATA_W-1:0]   m_cursor_value
);

    cdll_pkg::cmd_t cmd;

    cdll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cdll_dp #(
        .POOL_NODES (POOL_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_func         (s_func),
        .s_item_value   (s_item_value),
        .m_status       (m_status),
        .m_at_sentinel  (m_at_sentinel),
        .m_list_empty   (m_list_empty),
        .m_entry_count  (m_entry_count),
        .m_cursor_value (m_cursor_value)
    );

    // no second item enters while one is in work
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    a_sent_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_at_sentinel) |-> (m_cursor_value == '0))
        else $error("nonzero cursor value at sentinel");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_list_empty) |-> (m_entry_count == '0))
        else $error("empty list reports stored entries");

    a_capt_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.load ##1 cmd.exec ##1 cmd.fin)
        else $error("sequencer skipped a step");

endmodule
